>>> sv/dmm_pkg.sv
// Shared types and constants for the dense matrix multiply block.
// Command codes, register indexes, field widths, controller states and controller/datapath structs.
// No dependencies.
package dmm_pkg;

    // Fixed field widths
    localparam int DATA_W     = 32;   // Q16.16 element
    localparam int IDX_W      = 3;    // row / column field
    localparam int CMD_W      = 2;
    localparam int CFG_W      = 4;    // dimension register
    localparam int CFG_IDX_W  = 2;
    localparam int TDATA_W    = 40;   // row, col, value padded to bytes
    localparam int TDATA_USED = 2 * IDX_W + DATA_W;

    // Command codes carried in tuser
    localparam logic [CMD_W-1:0] CMD_WRITE_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MULTIPLY = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS     = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic a_we;       // write element of A
        logic b_we;       // write element of B
        logic rd_en;      // issue one MAC read pair
        logic rd_first;   // first term of a dot product
        logic rd_last;    // last term of a dot product
        logic emit;       // load result into output register
        logic emit_last;  // final element of the run
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic acc_done;   // accumulator holds a finished dot product
        logic out_free;   // output register can take a result
    } t_dp_status;

endpackage

>>> sv/dmm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/dmm_ctrl.sv
// Controller for the matrix multiply: dimension registers, load decode and
// the i/j/k sequencer that drives the MAC datapath. Uses dmm_pkg.
module dmm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [dmm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dmm_pkg::CFG_W-1:0]      i_cfg_wdata,
    // input channel control
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [dmm_pkg::CMD_W-1:0]      i_cmd,
    input  logic [dmm_pkg::IDX_W-1:0]      i_row,
    input  logic [dmm_pkg::IDX_W-1:0]      i_col,
    // datapath
    output dmm_pkg::t_ctrl_cmd             o_cmd,
    input  dmm_pkg::t_dp_status            i_status,
    output logic [$clog2(MAX_DIM)-1:0]     o_i,
    output logic [$clog2(MAX_DIM)-1:0]     o_j,
    output logic [$clog2(MAX_DIM)-1:0]     o_k
);
    import dmm_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int CNT_W = $clog2(MAX_DIM + 1);

    logic [CFG_W-1:0] r_a_rows, r_inner_size, r_b_cols;
    logic [CNT_W-1:0] m_dim, n_dim, p_dim;
    t_state           r_state, n_state;
    logic [DIM_W-1:0] r_i, r_j, r_k, n_i, n_j, n_k;
    logic             i_last, j_last, k_last;
    t_ctrl_cmd        cmd;

    // register value 0 acts as 1, above MAX_DIM acts as MAX_DIM
    function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return CNT_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            return CNT_W'(MAX_DIM);
        end else begin
            return CNT_W'(v);
        end
    endfunction

    // dimension registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows     <= CFG_RESET;
            r_inner_size <= CFG_RESET;
            r_b_cols     <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_A_ROWS:     r_a_rows     <= i_cfg_wdata;
                REG_INNER_SIZE: r_inner_size <= i_cfg_wdata;
                REG_B_COLS:     r_b_cols     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign m_dim = eff_dim(r_a_rows);
    assign n_dim = eff_dim(r_inner_size);
    assign p_dim = eff_dim(r_b_cols);

    // end-of-loop flags
    assign i_last = (CNT_W'(r_i) + CNT_W'(1)) == m_dim;
    assign j_last = (CNT_W'(r_j) + CNT_W'(1)) == p_dim;
    assign k_last = (CNT_W'(r_k) + CNT_W'(1)) == n_dim;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        cmd     = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    unique case (i_cmd)
                        CMD_WRITE_A: cmd.a_we = (i_row < m_dim) && (i_col < n_dim);
                        CMD_WRITE_B: cmd.b_we = (i_row < n_dim) && (i_col < p_dim);
                        CMD_MULTIPLY: begin
                            n_i     = '0;
                            n_j     = '0;
                            n_k     = '0;
                            n_state = ST_MAC;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MAC: begin
                // one A/B read pair per cycle
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (r_k == '0);
                cmd.rd_last  = k_last;
                if (k_last) begin
                    n_k     = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + DIM_W'(1);
                end
            end
            ST_DRAIN: begin
                if (i_status.acc_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = i_last && j_last;
                    if (j_last) begin
                        n_j = '0;
                        if (i_last) begin
                            n_i     = '0;
                            n_state = ST_IDLE;
                        end else begin
                            n_i     = r_i + DIM_W'(1);
                            n_state = ST_MAC;
                        end
                    end else begin
                        n_j     = r_j + DIM_W'(1);
                        n_state = ST_MAC;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cmd = cmd;
    assign o_i   = r_i;
    assign o_j   = r_j;
    assign o_k   = r_k;

endmodule

>>> sv/dmm_datapath.sv
// Datapath for the matrix multiply: A and B element stores, a registered
// 32x32 multiplier, a wide accumulator, rounding/saturation and the output
// register. Uses dmm_pkg and dmm_ram.
module dmm_datapath #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dmm_pkg::t_ctrl_cmd            i_cmd,
    output dmm_pkg::t_dp_status           o_status,
    input  logic [$clog2(MAX_DIM)-1:0]    i_i,
    input  logic [$clog2(MAX_DIM)-1:0]    i_j,
    input  logic [$clog2(MAX_DIM)-1:0]    i_k,
    // load item fields
    input  logic [dmm_pkg::IDX_W-1:0]     i_row,
    input  logic [dmm_pkg::IDX_W-1:0]     i_col,
    input  logic [dmm_pkg::DATA_W-1:0]    i_value,
    // result
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [dmm_pkg::IDX_W-1:0]     o_out_row,
    output logic [dmm_pkg::IDX_W-1:0]     o_out_col,
    output logic [dmm_pkg::DATA_W-1:0]    o_out_value,
    output logic                          o_out_last
);
    import dmm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = 2 * DATA_W + $clog2(MAX_DIM);

    logic [ADDR_W-1:0]         wr_addr, a_rd_addr, b_rd_addr;
    logic [DATA_W-1:0]         a_rdata, b_rdata;
    logic                      r_s1_valid, r_s1_first, r_s1_last;
    logic                      r_s2_valid, r_s2_first, r_s2_last;
    logic signed [2*DATA_W-1:0] r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_acc_done;
    logic signed [ACC_W-1:0]   acc_shr;
    logic [ACC_W-DATA_W:0]     acc_upper;
    logic [DATA_W-1:0]         sat_value;
    logic                      out_free;
    logic                      r_out_valid, r_out_last;
    logic [IDX_W-1:0]          r_out_row, r_out_col;
    logic [DATA_W-1:0]         r_out_value;

    // row-major address: row * MAX_DIM + column
    function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] r,
                                                  input logic [ADDR_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    assign wr_addr   = addr_of(ADDR_W'(i_row), ADDR_W'(i_col));
    assign a_rd_addr = addr_of(ADDR_W'(i_i), ADDR_W'(i_k));
    assign b_rd_addr = addr_of(ADDR_W'(i_k), ADDR_W'(i_j));

    // element stores
    dmm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.a_we),
        .i_waddr (wr_addr),
        .i_wdata (i_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (a_rd_addr),
        .o_rdata (a_rdata)
    );

    dmm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.b_we),
        .i_waddr (wr_addr),
        .i_wdata (i_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (b_rd_addr),
        .o_rdata (b_rdata)
    );

    // pipeline tags follow the read pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.rd_en;
            r_s2_valid <= r_s1_valid;
            r_acc_done <= r_s2_valid && r_s2_last;
        end
    end

    // multiply stage
    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.rd_first;
        r_s1_last  <= i_cmd.rd_last;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        if (r_s1_valid) begin
            r_prod <= $signed(a_rdata) * $signed(b_rdata);
        end
    end

    // accumulate stage, exact at full width
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            if (r_s2_first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // drop fraction bits (floor) and saturate to 32 bits
    assign acc_shr   = r_acc >>> FRAC_BITS;
    assign acc_upper = acc_shr[ACC_W-1:DATA_W-1];
    always_comb begin
        if ((&acc_upper) || !(|acc_upper)) begin
            sat_value = acc_shr[DATA_W-1:0];
        end else if (acc_shr[ACC_W-1]) begin
            sat_value = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_value = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_row   <= IDX_W'(i_i);
            r_out_col   <= IDX_W'(i_j);
            r_out_value <= sat_value;
            r_out_last  <= i_cmd.emit_last;
        end
    end

    assign o_status.acc_done = r_acc_done;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_row         = r_out_row;
    assign o_out_col         = r_out_col;
    assign o_out_value       = r_out_value;
    assign o_out_last        = r_out_last;

endmodule

>>> sv/dense_matrix_multiply_top.sv
// Dense matrix multiply C = A x B over signed Q16.16 elements.
// Top level: joins dmm_ctrl and dmm_datapath. Uses dmm_pkg.
//
// Usage:
//   Input stream (s_axis): tuser holds the command, tdata the row, column and
//   value. Write-A and write-B transactions store one element and are taken
//   one per cycle while idle; writes outside the configured size are dropped.
//   A multiply transaction streams all elements of C on m_axis in row-major
//   order, tlast on the final one. Unused command codes are dropped.
//   Dimensions sit in three 4-bit registers written over the cfg port
//   (0 counts as 1, values above MAX_DIM count as MAX_DIM); write them
//   only while the block is idle.
// Operation:
//   Each element of C is produced in turn: MAC reads (one A/B read pair
//   per cycle from the element RAMs), the multiply and accumulate pipeline
//   stages, a hand-off of the sum and a load of the output register. No input
//   transaction is taken until the last element is in the output register.
//   When the receiver stalls, the finished element waits in the output
//   register and the sequencer holds before loading the next one.
// Reset: i_rst_n is synchronous, active low; dimensions return to 8, the
//   output empties. Element stores are not cleared: load before multiplying.
module dense_matrix_multiply_top #(
    parameter int MAX_DIM   = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [dmm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dmm_pkg::CFG_W-1:0]      i_cfg_wdata,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dmm_pkg::TDATA_W-1:0]    s_axis_tdata,  // row_index[2:0], col_index[5:3],
                                                          // element_value[37:6], zero pad
    input  logic [dmm_pkg::CMD_W-1:0]      s_axis_tuser,  // cmd[1:0]
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [dmm_pkg::TDATA_W-1:0]    m_axis_tdata,  // out_row[2:0], out_col[5:3],
                                                          // product_value[37:6], zero pad
    output logic                           m_axis_tlast
);
    import dmm_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM);

    t_ctrl_cmd        ctrl_cmd;
    t_dp_status       dp_status;
    logic [DIM_W-1:0] cnt_i, cnt_j, cnt_k;
    logic [IDX_W-1:0] in_row, in_col, out_row, out_col;
    logic [DATA_W-1:0] in_value, out_value;

    // unpack input transaction
    assign in_row   = s_axis_tdata[IDX_W-1:0];
    assign in_col   = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign in_value = s_axis_tdata[TDATA_USED-1:2*IDX_W];

    dmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_row       (in_row),
        .i_col       (in_col),
        .o_cmd       (ctrl_cmd),
        .i_status    (dp_status),
        .o_i         (cnt_i),
        .o_j         (cnt_j),
        .o_k         (cnt_k)
    );

    dmm_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .i_i         (cnt_i),
        .i_j         (cnt_j),
        .i_k         (cnt_k),
        .i_row       (in_row),
        .i_col       (in_col),
        .i_value     (in_value),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_row   (out_row),
        .o_out_col   (out_col),
        .o_out_value (out_value),
        .o_out_last  (m_axis_tlast)
    );

    // pack output transaction
    assign m_axis_tdata = {{(TDATA_W-TDATA_USED){1'b0}}, out_value, out_col, out_row};

    // a multiply transaction closes the input until the run is done
    a_mult_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_MULTIPLY)
        |=> !s_axis_tready)
        else $error("input taken right after a multiply transaction");

    // a result is only loaded when the output register can take it
    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.emit |-> dp_status.out_free)
        else $error("result loaded over an untaken output");

    // MAC reads never overlap element writes
    a_no_read_write_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl_cmd.rd_en |-> !(ctrl_cmd.a_we || ctrl_cmd.b_we))
        else $error("element write during MAC reads");

    // the accumulator finishes only after the read sequence has stopped
    a_done_after_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_status.acc_done |-> !ctrl_cmd.rd_en && !s_axis_tready)
        else $error("dot product finished while reads or loads were active");

endmodule
